// File: hw/rtl/ctq_pkg.sv
// ----------------------------------------------------------------------------
// ctq_pkg
// Shared constants, codes and types of the credential table with daily quota.
// ----------------------------------------------------------------------------
package ctq_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  // Operation codes.
  localparam logic [2:0] MODE_CLEAR   = 3'd0;
  localparam logic [2:0] MODE_LOAD    = 3'd1;
  localparam logic [2:0] MODE_FIND_IP = 3'd2;
  localparam logic [2:0] MODE_FIND_ID = 3'd3;
  localparam logic [2:0] MODE_FIND_TG = 3'd4;
  localparam logic [2:0] MODE_REMAIN  = 3'd5;
  localparam logic [2:0] MODE_USE     = 3'd6;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_WRONG_PIN = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_BAD_INDEX = 3'd5;

  // Day value that means the time is not known.
  localparam logic signed [9:0] DAY_UNKNOWN = -10'sd1;

  typedef struct packed {
    logic [31:0]        id;
    logic [15:0]        pin;
    logic [31:0]        tag;
    logic [7:0]         quota;
    logic [7:0]         uses;
    logic signed [9:0]  last_day;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
    logic update;
    logic publish;
  } ctq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] mode;
    logic       index_bad;
    logic       hit;
    logic       miss;
    logic       out_free;
  } ctq_sts_t;

endpackage

// File: hw/rtl/ctq_ctrl.sv
// ----------------------------------------------------------------------------
// ctq_ctrl
// Controller state machine: sequences capture, execution, table scan,
// entry update and result hand-off.
// ----------------------------------------------------------------------------
module ctq_ctrl import ctq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctq_sts_t sts,
  output ctq_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.mode) inside
          MODE_FIND_IP, MODE_FIND_ID, MODE_FIND_TG, MODE_USE: state_next = S_SCAN;
          MODE_REMAIN: state_next = sts.index_bad ? S_FINISH : S_UPDATE;
          default:     state_next = S_FINISH;
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_next = (sts.mode == MODE_USE) ? S_UPDATE : S_FINISH;
        end else if (sts.miss) begin
          state_next = S_FINISH;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/ctq_dpath.sv
// ----------------------------------------------------------------------------
// ctq_dpath
// Datapath: operand registers, entry memory, entry count, scan pipeline,
// quota arithmetic and the output register.
// ----------------------------------------------------------------------------
module ctq_dpath import ctq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctq_cmd_t          cmd,
  output ctq_sts_t          sts,
  input  logic [2:0]        mode,
  input  logic [31:0]       key_id,
  input  logic [15:0]       key_pin,
  input  logic [31:0]       key_tag,
  input  logic [7:0]        entry_quota,
  input  logic signed [9:0] today,
  input  logic [7:0]        entry_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [7:0]        found_index,
  output logic signed [8:0] remaining,
  output logic [8:0]        user_count
);

  // Entry memory: one write port, one registered read port.
  entry_t mem [TABLE_DEPTH];

  // Operands of the word in progress.
  logic [2:0]        op_mode;
  logic [31:0]       op_id;
  logic [15:0]       op_pin;
  logic [31:0]       op_tag;
  logic [7:0]        op_quota;
  logic signed [9:0] op_today;
  logic [7:0]        op_index;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  scan_addr;
  logic              chk_valid;
  logic [IDX_W-1:0]  chk_addr;
  logic [IDX_W-1:0]  ent_addr;
  entry_t            rd_data;

  // Result of the word in progress.
  logic [2:0]        res_status;
  logic [IDX_W-1:0]  res_idx;
  logic signed [8:0] res_rem;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  entry_t            upd;
  logic              upd_wr;
  logic signed [8:0] upd_rem;
  logic              match;
  logic              index_bad;
  logic              table_full;
  logic              key_empty;

  assign index_bad  = (CNT_W'(op_index) >= count);
  assign table_full = (count == CNT_W'(TABLE_DEPTH));
  assign key_empty  = (op_id == 32'd0) && (op_tag == 32'd0);

  always_comb begin
    if (op_mode == MODE_FIND_TG) begin
      match = (op_tag != 32'd0) && (rd_data.tag == op_tag);
    end else begin
      match = (rd_data.id == op_id);
    end
  end

  assign sts.mode      = op_mode;
  assign sts.index_bad = index_bad;
  assign sts.hit       = chk_valid && match;
  assign sts.miss      = !chk_valid && (scan_addr >= count);
  assign sts.out_free  = !out_valid || out_ready;

  // Read port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_addr[IDX_W-1:0];
    if (cmd.scan && !sts.hit && (scan_addr < count)) begin
      rd_en = 1'b1;
    end else if (cmd.exec && (op_mode == MODE_REMAIN) && !index_bad) begin
      rd_en   = 1'b1;
      rd_addr = op_index[IDX_W-1:0];
    end
  end

  // Read-modify-write of a found entry for the remaining and record-use
  // operations.
  always_comb begin
    upd     = rd_data;
    upd_wr  = 1'b0;
    upd_rem = $signed({1'b0, rd_data.quota});
    if (op_mode == MODE_USE) begin
      if (op_today != DAY_UNKNOWN) begin
        upd.last_day = op_today;
        upd.uses     = (rd_data.uses == 8'hFF) ? rd_data.uses : rd_data.uses + 8'd1;
        upd_wr       = 1'b1;
      end
      upd_rem = $signed({1'b0, rd_data.quota}) - $signed({1'b0, upd.uses});
    end else if (op_today != DAY_UNKNOWN) begin
      if (rd_data.last_day != op_today) begin
        upd.uses     = 8'd0;
        upd.last_day = op_today;
        upd_wr       = 1'b1;
      end
      upd_rem = $signed({1'b0, rd_data.quota}) - $signed({1'b0, upd.uses});
    end
  end

  // Write port control.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[IDX_W-1:0];
    wr_data = upd;
    if (cmd.exec && (op_mode == MODE_LOAD) && !table_full && !key_empty) begin
      wr_en            = 1'b1;
      wr_data.id       = op_id;
      wr_data.pin      = op_pin;
      wr_data.tag      = op_tag;
      wr_data.quota    = op_quota;
      wr_data.uses     = 8'd0;
      wr_data.last_day = DAY_UNKNOWN;
    end else if (cmd.update && upd_wr) begin
      wr_en   = 1'b1;
      wr_addr = ent_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec && (op_mode == MODE_CLEAR)) begin
        count <= '0;
      end else if (cmd.exec && (op_mode == MODE_LOAD) && !table_full && !key_empty) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.exec) begin
        chk_valid <= 1'b0;
      end else if (cmd.scan) begin
        chk_valid <= rd_en;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Operands, scan pointers, result and output payload.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_mode  <= mode;
      op_id    <= key_id;
      op_pin   <= key_pin;
      op_tag   <= key_tag;
      op_quota <= entry_quota;
      op_today <= today;
      op_index <= entry_index;
    end

    if (cmd.exec) begin
      scan_addr <= '0;
      ent_addr  <= op_index[IDX_W-1:0];
      res_rem   <= '0;
      case (op_mode)
        MODE_LOAD: begin
          if (table_full) begin
            res_status <= ST_FULL;
            res_idx    <= '0;
          end else if (key_empty) begin
            res_status <= ST_EMPTY;
            res_idx    <= '0;
          end else begin
            res_status <= ST_OK;
            res_idx    <= count[IDX_W-1:0];
          end
        end
        MODE_REMAIN: begin
          res_idx    <= op_index[IDX_W-1:0];
          res_status <= index_bad ? ST_BAD_INDEX : ST_OK;
        end
        default: begin
          res_status <= ST_OK;
          res_idx    <= '0;
        end
      endcase
    end

    if (cmd.scan) begin
      if (rd_en) begin
        scan_addr <= scan_addr + CNT_W'(1);
        chk_addr  <= scan_addr[IDX_W-1:0];
      end
      if (sts.hit) begin
        ent_addr <= chk_addr;
        res_idx  <= chk_addr;
        if ((op_mode == MODE_FIND_IP) && (rd_data.pin != op_pin)) begin
          res_status <= ST_WRONG_PIN;
        end else begin
          res_status <= ST_OK;
        end
      end else if (sts.miss) begin
        res_status <= ST_NOT_FOUND;
      end
    end

    if (cmd.update) begin
      res_rem <= upd_rem;
    end

    if (cmd.publish) begin
      status      <= res_status;
      found_index <= 8'(res_idx);
      remaining   <= res_rem;
      user_count  <= 9'(count);
    end
  end

endmodule

// File: hw/rtl/credential_table_with_daily_quota.sv
// ----------------------------------------------------------------------------
// credential_table_with_daily_quota
// Table of user credentials (id, PIN, tag, daily quota) with lookups and
// per-day use counting.
// ----------------------------------------------------------------------------
// The block holds up to 256 entries in one on-chip memory and takes one
// operation word at a time; each word gives exactly one result word. Clear,
// load, a remaining-quota query with a bad index and the unused mode code go
// from the execute step straight to the finish step. A remaining-quota query
// on a valid index reads its entry in the execute step and passes through an
// update step before the finish step. The lookups (find by id and PIN, find
// by id, find by tag, record use) scan the valid entries from position zero
// upward through the single memory read port, one entry per cycle, and stop
// at the first match; a lookup that misses reads every valid entry. A record
// use that matches then passes through the update step for the write back of
// the entry. A new word is accepted only when the previous one has finished
// its work; the finished result sits in an output register, so the next word
// is taken while that result still waits for the consumer. The stores hold
// no reset value: only positions below the entry count are ever read, and
// each load writes the whole entry.
module credential_table_with_daily_quota import ctq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        mode,
  input  logic [31:0]       key_id,
  input  logic [15:0]       key_pin,
  input  logic [31:0]       key_tag,
  input  logic [7:0]        entry_quota,
  input  logic signed [9:0] today,
  input  logic [7:0]        entry_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [7:0]        found_index,
  output logic signed [8:0] remaining,
  output logic [8:0]        user_count
);

  ctq_cmd_t cmd;
  ctq_sts_t sts;

  // The controller decides which step the current word is in.
  ctq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the table, the operands and the result registers.
  ctq_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .mode        (mode),
    .key_id      (key_id),
    .key_pin     (key_pin),
    .key_tag     (key_tag),
    .entry_quota (entry_quota),
    .today       (today),
    .entry_index (entry_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_index (found_index),
    .remaining   (remaining),
    .user_count  (user_count)
  );

endmodule
